// File: design/exlex_pkg.sv
// shared types, constants and helpers for the expression lexer
// no dependencies; imported by every exlex module
`default_nettype none

package exlex_pkg;

   localparam int TOK_W       = 16;
   localparam int RUN_MAX     = 4;
   localparam int RUN_CNT_W   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [7:0] ASCII_SPACE  = 8'h20;
   localparam logic [7:0] ASCII_PLUS   = 8'h2B;
   localparam logic [7:0] ASCII_MINUS  = 8'h2D;
   localparam logic [7:0] ASCII_STAR   = 8'h2A;
   localparam logic [7:0] ASCII_SLASH  = 8'h2F;
   localparam logic [7:0] ASCII_CARET  = 8'h5E;
   localparam logic [7:0] ASCII_LPAREN = 8'h28;
   localparam logic [7:0] ASCII_RPAREN = 8'h29;
   localparam logic [7:0] ASCII_DOT    = 8'h2E;
   localparam logic [7:0] ASCII_LOW_E  = 8'h65;
   localparam logic [7:0] ASCII_UP_E   = 8'h45;
   localparam logic [7:0] ASCII_0      = 8'h30;
   localparam logic [7:0] ASCII_9      = 8'h39;
   localparam logic [7:0] ASCII_LOW_A  = 8'h61;
   localparam logic [7:0] ASCII_LOW_Z  = 8'h7A;
   localparam logic [7:0] ASCII_UP_A   = 8'h41;
   localparam logic [7:0] ASCII_UP_Z   = 8'h5A;

   typedef enum logic [3:0] {
      TK_PLUS   = 4'd0,
      TK_MINUS  = 4'd1,
      TK_MUL    = 4'd2,
      TK_DIV    = 4'd3,
      TK_EXP    = 4'd4,
      TK_LPAREN = 4'd5,
      TK_RPAREN = 4'd6,
      TK_NUMBER = 4'd7,
      TK_IDENT  = 4'd8,
      TK_END    = 4'd9,
      TK_ERROR  = 4'd10
   } tok_kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE     = 4'd0,
      MODE_DOT      = 4'd1,
      MODE_INT      = 4'd2,
      MODE_FRAC     = 4'd3,
      MODE_EXP_E    = 4'd4,
      MODE_EXP_SIGN = 4'd5,
      MODE_EXP_DIG  = 4'd6,
      MODE_IDENT    = 4'd7,
      MODE_ERROR    = 4'd8
   } scan_mode_type;

   typedef enum logic [2:0] {
      CH_SPACE,
      CH_OP,
      CH_DIGIT,
      CH_DOT,
      CH_ALPHA,
      CH_BAD
   } ch_class_type;

   typedef struct packed {
      tok_kind_type     kind;
      logic [TOK_W-1:0] start;
      logic [TOK_W-1:0] length;
   } tok_type;

   typedef struct packed {
      logic [RUN_CNT_W-1:0]      cnt;
      tok_type [RUN_MAX-1:0]     tok;
   } run_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } q_stat_type;

   function automatic tok_kind_type op_kind(logic [7:0] c);
      tok_kind_type k;
      case (c)
         ASCII_PLUS:   k = TK_PLUS;
         ASCII_MINUS:  k = TK_MINUS;
         ASCII_STAR:   k = TK_MUL;
         ASCII_SLASH:  k = TK_DIV;
         ASCII_CARET:  k = TK_EXP;
         ASCII_LPAREN: k = TK_LPAREN;
         ASCII_RPAREN: k = TK_RPAREN;
         default:      k = TK_ERROR;
      endcase
      return k;
   endfunction

   function automatic ch_class_type classify(logic [7:0] c);
      ch_class_type cls;
      if (c == ASCII_SPACE) begin
         cls = CH_SPACE;
      end else if (op_kind(c) != TK_ERROR) begin
         cls = CH_OP;
      end else if (c >= ASCII_0 && c <= ASCII_9) begin
         cls = CH_DIGIT;
      end else if (c == ASCII_DOT) begin
         cls = CH_DOT;
      end else if ((c >= ASCII_LOW_A && c <= ASCII_LOW_Z) ||
                   (c >= ASCII_UP_A && c <= ASCII_UP_Z)) begin
         cls = CH_ALPHA;
      end else begin
         cls = CH_BAD;
      end
      return cls;
   endfunction

   // mode entered when a character starts a new token
   function automatic scan_mode_type begin_mode(ch_class_type cls);
      scan_mode_type m;
      case (cls)
         CH_DIGIT: m = MODE_INT;
         CH_DOT:   m = MODE_DOT;
         CH_ALPHA: m = MODE_IDENT;
         CH_BAD:   m = MODE_ERROR;
         default:  m = MODE_IDLE;
      endcase
      return m;
   endfunction

   function automatic run_type add_tok(run_type r, tok_kind_type k,
                                       logic [TOK_W-1:0] s, logic [TOK_W-1:0] l);
      run_type o;
      o = r;
      if (r.cnt < RUN_CNT_W'(RUN_MAX)) begin
         o.tok[r.cnt[QPTR_W-1:0]] = '{kind: k, start: s, length: l};
         o.cnt = r.cnt + RUN_CNT_W'(1);
      end
      return o;
   endfunction

endpackage

`default_nettype wire

// File: design/exlex_front.sv
// front end: takes one req word per cycle while accept is high, tracks the scan
// mode and builds the run of tokens it causes; uses exlex_pkg
`default_nettype none

module exlex_front #(
   parameter int POS_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               in_kind,
   input  wire logic [7:0]         in_ch,
   output exlex_pkg::run_type      run,
   output logic                    push
);
   import exlex_pkg::*;

   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   scan_mode_type       mode_ff,  mode_in;
   logic [POS_BITS-1:0] start_ff, start_in;
   logic [POS_BITS-1:0] pos_ff,   pos_in;
   logic                minus_ff, minus_in;
   logic                restart;

   ch_class_type        cls;
   logic                is_dig, is_alpha, is_e, is_sign, at_max;
   logic [POS_BITS-1:0] pos_m1, pos_m2;
   logic [TOK_W-1:0]    p_t, p1_t, p2_t, st_t, len_open, len_pre_e, len_pre_sign;
   run_type             run_c;

   function automatic logic [TOK_W-1:0] to_tok(logic [POS_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[TOK_W-1:0];
   endfunction

   // token emitted by a character that starts a new token, if any
   function automatic run_type begin_emit(run_type r, ch_class_type c_cls,
                                          logic [7:0] c, logic [TOK_W-1:0] p);
      run_type o;
      o = r;
      if (c_cls == CH_OP) begin
         o = add_tok(r, op_kind(c), p, TOK_W'(1));
      end else if (c_cls == CH_BAD) begin
         o = add_tok(r, TK_ERROR, p, TOK_W'(1));
      end
      return o;
   endfunction

   assign cls      = classify(in_ch);
   assign is_dig   = (cls == CH_DIGIT);
   assign is_alpha = (cls == CH_ALPHA);
   assign is_e     = (in_ch == ASCII_LOW_E) || (in_ch == ASCII_UP_E);
   assign is_sign  = (in_ch == ASCII_PLUS) || (in_ch == ASCII_MINUS);
   assign at_max   = (pos_ff == POS_MAX);
   assign pos_m1   = pos_ff - POS_BITS'(1);
   assign pos_m2   = pos_ff - POS_BITS'(2);

   assign p_t          = to_tok(pos_ff);
   assign p1_t         = to_tok(pos_m1);
   assign p2_t         = to_tok(pos_m2);
   assign st_t         = to_tok(start_ff);
   assign len_open     = to_tok(pos_ff - start_ff);
   assign len_pre_e    = to_tok(pos_m1 - start_ff);
   assign len_pre_sign = to_tok(pos_m2 - start_ff);

   // next state
   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      minus_in = minus_ff;
      restart  = 1'b0;
      if (in_kind == KIND_END) begin
         mode_in  = MODE_IDLE;
         start_in = '0;
         pos_in   = '0;
         minus_in = 1'b0;
      end else if (mode_ff == MODE_ERROR) begin
         if (!at_max) begin
            pos_in = pos_ff + POS_BITS'(1);
         end
      end else if (at_max) begin
         mode_in = MODE_ERROR;
      end else begin
         pos_in = pos_ff + POS_BITS'(1);
         case (mode_ff)
            MODE_IDLE: begin
               restart = 1'b1;
            end
            MODE_DOT: begin
               mode_in = is_dig ? MODE_FRAC : MODE_ERROR;
            end
            MODE_INT, MODE_FRAC: begin
               if (is_dig) begin
                  mode_in = mode_ff;
               end else if (cls == CH_DOT && mode_ff == MODE_INT) begin
                  mode_in = MODE_FRAC;
               end else if (is_e) begin
                  mode_in = MODE_EXP_E;
               end else begin
                  restart = 1'b1;
               end
            end
            MODE_EXP_E: begin
               if (is_dig) begin
                  mode_in = MODE_EXP_DIG;
               end else if (is_sign) begin
                  mode_in  = MODE_EXP_SIGN;
                  minus_in = (in_ch == ASCII_MINUS);
               end else begin
                  start_in = pos_m1;
                  if (is_alpha) begin
                     mode_in = MODE_IDENT;
                  end else begin
                     restart = 1'b1;
                  end
               end
            end
            MODE_EXP_SIGN: begin
               if (is_dig) begin
                  mode_in = MODE_EXP_DIG;
               end else begin
                  restart = 1'b1;
               end
            end
            MODE_EXP_DIG, MODE_IDENT: begin
               if (!((mode_ff == MODE_EXP_DIG) ? is_dig : is_alpha)) begin
                  restart = 1'b1;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
         if (restart) begin
            mode_in = begin_mode(cls);
            if (is_dig || is_alpha || cls == CH_DOT) begin
               start_in = pos_ff;
            end
         end
      end
   end

   // tokens caused by this word
   always_comb begin
      run_c = '0;
      if (in_kind == KIND_END) begin
         case (mode_ff)
            MODE_DOT: begin
               run_c = add_tok(run_c, TK_ERROR, st_t, TOK_W'(1));
            end
            MODE_INT, MODE_FRAC, MODE_EXP_DIG: begin
               run_c = add_tok(run_c, TK_NUMBER, st_t, len_open);
            end
            MODE_EXP_E: begin
               run_c = add_tok(run_c, TK_NUMBER, st_t, len_pre_e);
               run_c = add_tok(run_c, TK_IDENT, p1_t, TOK_W'(1));
            end
            MODE_EXP_SIGN: begin
               run_c = add_tok(run_c, TK_NUMBER, st_t, len_pre_sign);
               run_c = add_tok(run_c, TK_IDENT, p2_t, TOK_W'(1));
               run_c = add_tok(run_c, minus_ff ? TK_MINUS : TK_PLUS, p1_t, TOK_W'(1));
            end
            MODE_IDENT: begin
               run_c = add_tok(run_c, TK_IDENT, st_t, len_open);
            end
            default: begin
               run_c = '0;
            end
         endcase
         run_c = add_tok(run_c, TK_END, p_t, '0);
      end else if (mode_ff == MODE_ERROR) begin
         run_c = '0;
      end else if (at_max) begin
         run_c = add_tok(run_c, TK_ERROR, p_t, '0);
      end else begin
         case (mode_ff)
            MODE_IDLE: begin
               run_c = begin_emit(run_c, cls, in_ch, p_t);
            end
            MODE_DOT: begin
               if (!is_dig) begin
                  run_c = add_tok(run_c, TK_ERROR, st_t, TOK_W'(1));
               end
            end
            MODE_INT, MODE_FRAC: begin
               if (!(is_dig || (cls == CH_DOT && mode_ff == MODE_INT) || is_e)) begin
                  run_c = add_tok(run_c, TK_NUMBER, st_t, len_open);
                  run_c = begin_emit(run_c, cls, in_ch, p_t);
               end
            end
            MODE_EXP_E: begin
               if (!(is_dig || is_sign)) begin
                  run_c = add_tok(run_c, TK_NUMBER, st_t, len_pre_e);
                  if (!is_alpha) begin
                     run_c = add_tok(run_c, TK_IDENT, p1_t, TOK_W'(1));
                     run_c = begin_emit(run_c, cls, in_ch, p_t);
                  end
               end
            end
            MODE_EXP_SIGN: begin
               if (!is_dig) begin
                  run_c = add_tok(run_c, TK_NUMBER, st_t, len_pre_sign);
                  run_c = add_tok(run_c, TK_IDENT, p2_t, TOK_W'(1));
                  run_c = add_tok(run_c, minus_ff ? TK_MINUS : TK_PLUS, p1_t,
                                  TOK_W'(1));
                  run_c = begin_emit(run_c, cls, in_ch, p_t);
               end
            end
            MODE_EXP_DIG: begin
               if (!is_dig) begin
                  run_c = add_tok(run_c, TK_NUMBER, st_t, len_open);
                  run_c = begin_emit(run_c, cls, in_ch, p_t);
               end
            end
            MODE_IDENT: begin
               if (!is_alpha) begin
                  run_c = add_tok(run_c, TK_IDENT, st_t, len_open);
                  run_c = begin_emit(run_c, cls, in_ch, p_t);
               end
            end
            default: begin
               run_c = '0;
            end
         endcase
      end
   end

   assign run  = run_c;
   assign push = accept && (run_c.cnt != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         pos_ff   <= '0;
         minus_ff <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         minus_ff <= minus_in;
      end
   end

endmodule

`default_nettype wire

// File: design/exlex_queue.sv
// short queue of token runs between the front end and the back end
// uses exlex_pkg for the run and status types
`default_nettype none

module exlex_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire exlex_pkg::run_type   push_run,
   input  wire logic                 pop,
   output exlex_pkg::run_type        head,
   output exlex_pkg::q_stat_type     stat
);
   import exlex_pkg::*;

   run_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     fill_ff,   fill_in;

   assign wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;

   always_comb begin
      case ({push, pop})
         2'b10:   fill_in = fill_ff + (QPTR_W+1)'(1);
         2'b01:   fill_in = fill_ff - (QPTR_W+1)'(1);
         default: fill_in = fill_ff;
      endcase
   end

   assign head          = slot_ff[rd_ptr_ff];
   assign stat.full     = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign stat.nonempty = (fill_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

`default_nettype wire

// File: design/exlex_back.sv
// back end: walks the head run into the output register one token per cycle
// while rsp_stall is low; uses exlex_pkg for the run and status types
`default_nettype none

module exlex_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire exlex_pkg::run_type         head,
   input  wire exlex_pkg::q_stat_type      stat,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [3:0]                      rsp_token_kind,
   output logic [exlex_pkg::TOK_W-1:0]     rsp_token_start,
   output logic [exlex_pkg::TOK_W-1:0]     rsp_token_length,
   output logic                            rsp_last_of_run
);
   import exlex_pkg::*;

   logic              valid_ff, valid_in;
   logic [QPTR_W-1:0] idx_ff,   idx_in;
   tok_type           tok_ff;
   logic              last_ff;
   logic              load, take, last_tok;

   assign load     = !valid_ff || !rsp_stall;
   assign take     = load && stat.nonempty;
   assign last_tok = ({1'b0, idx_ff} + RUN_CNT_W'(1)) == head.cnt;
   assign pop      = take && last_tok;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last_tok ? '0 : idx_ff + QPTR_W'(1);
      end
   end

   assign valid_in = load ? stat.nonempty : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tok_ff  <= head.tok[idx_ff];
         last_ff <= last_tok;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_token_kind   = tok_ff.kind;
   assign rsp_token_start  = tok_ff.start;
   assign rsp_token_length = tok_ff.length;
   assign rsp_last_of_run  = last_ff;

endmodule

`default_nettype wire

// File: design/expression_lexer.sv
// expression_lexer: streaming tokenizer for arithmetic expression text
// instantiates exlex_front, exlex_queue and exlex_back; uses exlex_pkg
//
// req channel: one word per character (req_kind = 0, byte on req_ch) and one
// word with req_kind = 1 that closes the text. rsp channel: tokens with kind,
// start position, length and a flag on the last token caused by one req word.
// Both channels: a word moves on a clock edge with valid high and stall low.
// A req word can be taken every cycle while req_stall is low; each word
// yields zero to four tokens. The run of tokens of a word is written into
// the queue, and the back end moves it token by token into the output
// register; tokens leave at one per cycle while rsp_stall is low. A
// four-entry run queue between the scanner and the output register absorbs
// multi-token runs; req_stall rises only when it is full.
// While rsp_stall is high the output word holds and the queue fills behind it.
// Reset (synchronous) returns the scanner to position 0 between tokens and
// empties the queue and output register. After an end-of-text word the scanner
// state is restored, so the next character starts a new text at position 0.
`default_nettype none

module expression_lexer #(
   parameter int POS_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_kind,
   input  wire logic [7:0]              req_ch,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [3:0]                   rsp_token_kind,
   output logic [exlex_pkg::TOK_W-1:0]  rsp_token_start,
   output logic [exlex_pkg::TOK_W-1:0]  rsp_token_length,
   output logic                         rsp_last_of_run
);
   import exlex_pkg::*;

   logic       accept;
   logic       push, pop;
   run_type    push_run, head;
   q_stat_type stat;

   assign req_stall = stat.full;
   assign accept    = req_valid && !req_stall;

   exlex_front #(
      .POS_BITS (POS_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_kind (req_kind),
      .in_ch   (req_ch),
      .run     (push_run),
      .push    (push)
   );

   exlex_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .head     (head),
      .stat     (stat)
   );

   exlex_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .stat             (stat),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

`ifndef SYNTH
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind == TK_END) |-> rsp_last_of_run)
      else $error("end token not last of its run");

   a_end_zero_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind == TK_END) |-> (rsp_token_length == '0))
      else $error("end token with nonzero length");

   a_error_short: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind == TK_ERROR) |->
      (rsp_token_length == '0 || rsp_token_length == TOK_W'(1)))
      else $error("error token longer than one character");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output word valid right after reset");
`endif

endmodule

`default_nettype wire
